[rtl/core/mrpt_pkg.sv]
package mrpt_pkg;

   localparam int unsigned WIT_COUNT   = 12;
   localparam int unsigned WIT_IDX_W   = 4;
   localparam int unsigned WIT_VAL_W   = 6;
   localparam int unsigned RSP_TDATA_W = 8;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_CHECK    = 11'b000_0000_0010,
      ST_SPLIT    = 11'b000_0000_0100,
      ST_WIT      = 11'b000_0000_1000,
      ST_POW      = 11'b000_0001_0000,
      ST_WAIT_ACC = 11'b000_0010_0000,
      ST_WAIT_SQ  = 11'b000_0100_0000,
      ST_XCHK     = 11'b000_1000_0000,
      ST_SQLOOP   = 11'b001_0000_0000,
      ST_WAIT_X   = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } mr_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

   function automatic logic [WIT_VAL_W-1:0] wit_value(input logic [WIT_IDX_W-1:0] idx);
      logic [WIT_VAL_W-1:0] val;
      case (idx)
         4'd0:    val = 6'd2;
         4'd1:    val = 6'd3;
         4'd2:    val = 6'd5;
         4'd3:    val = 6'd7;
         4'd4:    val = 6'd11;
         4'd5:    val = 6'd13;
         4'd6:    val = 6'd17;
         4'd7:    val = 6'd19;
         4'd8:    val = 6'd23;
         4'd9:    val = 6'd29;
         4'd10:   val = 6'd31;
         4'd11:   val = 6'd37;
         default: val = 6'd0;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/mrpt_modmul.sv]
module mrpt_modmul import mrpt_pkg::*; #(
   parameter int unsigned NUM_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] op_a,
   input  logic [NUM_WIDTH-1:0] op_b,
   input  logic [NUM_WIDTH-1:0] modulus,
   output mm_stat_type          stat,
   output logic [NUM_WIDTH-1:0] product
);

   localparam int unsigned CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] a_ff, a_in;
   logic [NUM_WIDTH-1:0] b_ff, b_in;
   logic [NUM_WIDTH-1:0] m_ff, m_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [NUM_WIDTH:0]   dbl;
   logic [NUM_WIDTH:0]   dbl_red;
   logic [NUM_WIDTH:0]   sum;
   logic [NUM_WIDTH-1:0] step_val;

   // one multiplier bit per cycle, msb first: acc = 2*acc (+ a) mod m
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = dbl_red + {1'b0, a_ff};
      if (b_ff[NUM_WIDTH-1]) begin
         if (sum >= {1'b0, m_ff}) begin
            sum = sum - {1'b0, m_ff};
         end
         step_val = sum[NUM_WIDTH-1:0];
      end else begin
         step_val = dbl_red[NUM_WIDTH-1:0];
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
         cnt_in  = CNT_W'(NUM_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = step_val;
         b_in   = {b_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

[rtl/core/miller_rabin_primality_test.sv]
// channel   dir  tdata                      tuser  tlast
// req_      in   candidate [63:0]           -      -
// rsp_      out  is_prime [0], zero [7:1]   -      -
//
// one candidate at a time; req_tready is high only while idle
// each modular multiply runs in the shared shift-add unit
// an odd candidate needs up to about 2*NUM_WIDTH multiplies per witness
// a result waits in the output register; a low rsp_tready stalls only the final step
// synchronous active-high reset clears the sequencer and the output valid
module miller_rabin_primality_test import mrpt_pkg::*; #(
   parameter int unsigned NUM_WIDTH     = 64,
   parameter int unsigned NUM_WITNESSES = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,  // candidate [63:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // is_prime [0], zero [7:1]
);

   localparam int unsigned SW = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   mr_state_type         state_ff, state_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] nm1_ff, nm1_in;
   logic [NUM_WIDTH-1:0] d_ff, d_in;
   logic [NUM_WIDTH-1:0] e_ff, e_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] base_ff, base_in;
   logic [SW-1:0]        s_ff, s_in;
   logic [SW-1:0]        r_ff, r_in;
   logic [WIT_IDX_W-1:0] w_ff, w_in;
   logic                 res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;

   logic                 mm_start;
   logic [NUM_WIDTH-1:0] mm_a;
   logic [NUM_WIDTH-1:0] mm_b;
   mm_stat_type          mm_stat;
   logic [NUM_WIDTH-1:0] mm_product;
   logic [NUM_WIDTH-1:0] wit;

   mrpt_modmul #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (n_ff),
      .stat    (mm_stat),
      .product (mm_product)
   );

   assign wit        = NUM_WIDTH'(wit_value(w_ff));
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      w_in         = w_ff;
      res_in       = res_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_valid_in = rsp_valid_ff;
      mm_start     = 1'b0;
      mm_a         = acc_ff;
      mm_b         = base_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in     = req_tdata[NUM_WIDTH-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (n_ff < NUM_WIDTH'(2)) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else if (n_ff == NUM_WIDTH'(2) || n_ff == NUM_WIDTH'(3)) begin
               res_in   = 1'b1;
               state_in = ST_DONE;
            end else if (!n_ff[0]) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               nm1_in   = n_ff - 1'b1;
               d_in     = n_ff - 1'b1;
               s_in     = '0;
               w_in     = '0;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (d_ff[0]) begin
               state_in = ST_WIT;
            end else begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end
         end
         ST_WIT: begin
            if (w_ff == WIT_IDX_W'(NUM_WITNESSES) || n_ff <= wit) begin
               res_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               acc_in   = NUM_WIDTH'(1);
               base_in  = wit;
               e_in     = d_ff;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            if (e_ff == '0) begin
               state_in = ST_XCHK;
            end else if (e_ff[0]) begin
               mm_start = 1'b1;
               mm_a     = acc_ff;
               mm_b     = base_ff;
               state_in = ST_WAIT_ACC;
            end else begin
               mm_start = 1'b1;
               mm_a     = base_ff;
               mm_b     = base_ff;
               state_in = ST_WAIT_SQ;
            end
         end
         ST_WAIT_ACC: begin
            if (mm_stat.done) begin
               acc_in   = mm_product;
               mm_start = 1'b1;
               mm_a     = base_ff;
               mm_b     = base_ff;
               state_in = ST_WAIT_SQ;
            end
         end
         ST_WAIT_SQ: begin
            if (mm_stat.done) begin
               base_in  = mm_product;
               e_in     = e_ff >> 1;
               state_in = ST_POW;
            end
         end
         ST_XCHK: begin
            if (acc_ff == NUM_WIDTH'(1) || acc_ff == nm1_ff) begin
               w_in     = w_ff + 1'b1;
               state_in = ST_WIT;
            end else begin
               r_in     = SW'(1);
               state_in = ST_SQLOOP;
            end
         end
         ST_SQLOOP: begin
            if (r_ff >= s_ff) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else if (!mm_stat.busy) begin
               mm_start = 1'b1;
               mm_a     = acc_ff;
               mm_b     = acc_ff;
               state_in = ST_WAIT_X;
            end
         end
         ST_WAIT_X: begin
            if (mm_stat.done) begin
               acc_in = mm_product;
               if (mm_product == nm1_ff) begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_WIT;
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = ST_SQLOOP;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      nm1_ff     <= nm1_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      acc_ff     <= acc_in;
      base_ff    <= base_in;
      s_ff       <= s_in;
      r_ff       <= r_in;
      w_ff       <= w_in;
      res_ff     <= res_in;
      rsp_bit_ff <= rsp_bit_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_bit_ff};

endmodule
